### src/lav_pkg.sv
// Look-at view matrix: shared types and constants.
// Depends on nothing; every module of the block imports it.
`default_nettype none
package lav_pkg;

    localparam int LAV_FRAC_BITS = 16;
    localparam int LAV_QDEPTH    = 2;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] upward_x;
        logic signed [31:0] upward_y;
        logic signed [31:0] upward_z;
    } lav_in_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               degenerate;
        logic               last_row;
    } lav_out_t;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
        logic signed [32:0] d_x;
        logic signed [32:0] d_y;
        logic signed [32:0] d_z;
        logic               d_zero;
    } lav_job_t;

endpackage
`default_nettype wire

### src/lav_front.sv
// Look-at view matrix front end: accepts camera items, forms eye - target
// and flags a zero view direction. Depends on lav_pkg.
`default_nettype none
module lav_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire lav_pkg::lav_in_t s_data,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output lav_pkg::lav_job_t     push_job
);
    import lav_pkg::*;

    logic     valid_reg;
    lav_job_t job_reg;
    lav_job_t job_next;

    always_comb begin
        job_next.eye_x = s_data.eye_x;
        job_next.eye_y = s_data.eye_y;
        job_next.eye_z = s_data.eye_z;
        job_next.up_x  = s_data.upward_x;
        job_next.up_y  = s_data.upward_y;
        job_next.up_z  = s_data.upward_z;
        job_next.d_x   = {s_data.eye_x[31], s_data.eye_x}
                       - {s_data.target_x[31], s_data.target_x};
        job_next.d_y   = {s_data.eye_y[31], s_data.eye_y}
                       - {s_data.target_y[31], s_data.target_y};
        job_next.d_z   = {s_data.eye_z[31], s_data.eye_z}
                       - {s_data.target_z[31], s_data.target_z};
        job_next.d_zero = (job_next.d_x == '0) && (job_next.d_y == '0)
                       && (job_next.d_z == '0);
    end

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_job   = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
            job_reg   <= job_next;
        end else if (push_ready) begin
            valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

### src/lav_fifo.sv
// Look-at view matrix job queue between front and back end.
// Depends on lav_pkg.
`default_nettype none
module lav_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire lav_pkg::lav_job_t wr_job,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output lav_pkg::lav_job_t      rd_job
);
    import lav_pkg::*;

    localparam int AW = (LAV_QDEPTH > 1) ? $clog2(LAV_QDEPTH) : 1;

    lav_job_t        mem [LAV_QDEPTH];
    logic [AW-1:0]   wptr_reg;
    logic [AW-1:0]   rptr_reg;
    logic [AW:0]     count_reg;
    logic            do_wr;
    logic            do_rd;

    assign wr_ready = (count_reg != (AW+1)'(LAV_QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = mem[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_wr) begin
                wptr_reg <= (wptr_reg == AW'(LAV_QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd) begin
                rptr_reg <= (rptr_reg == AW'(LAV_QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### src/lav_back.sv
// Look-at view matrix back end: sequencer with one shared multiplier,
// bit-serial square root and divider, and the result register. Depends on lav_pkg.
`default_nettype none
module lav_back #(
    parameter int FRAC_BITS = lav_pkg::LAV_FRAC_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  wire lav_pkg::lav_job_t job,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lav_pkg::lav_out_t      m_data
);
    import lav_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_NRM_INIT, ST_NRM_SHIFT, ST_MUL, ST_ACC,
        ST_SQRT, ST_DIV_INIT, ST_DIV_STEP, ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_SQ, OP_CROSS_C, OP_CROSS_Y, OP_DOT_X, OP_DOT_Y, OP_DOT_Z
    } op_t;

    localparam logic [63:0] RND_HALF = 64'(1) << (FRAC_BITS - 1);
    localparam logic signed [31:0] ONE_Q = 32'(64'(1) << FRAC_BITS);

    state_t             state_reg;
    op_t                op_reg;
    logic               pass_reg;
    logic [2:0]         k_reg;
    logic               degen_reg;
    logic signed [31:0] eye_reg [3];
    logic signed [31:0] up_reg  [3];
    logic signed [31:0] z_reg   [3];
    logic signed [31:0] x_reg   [3];
    logic signed [31:0] y_reg   [3];
    logic signed [31:0] t_reg   [3];
    logic signed [63:0] vec_reg [3];
    logic [63:0]        m_reg   [3];
    logic               neg_reg [3];
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic [63:0]        sq_n_reg;
    logic [63:0]        sq_res_reg;
    logic [4:0]         sq_cnt_reg;
    logic [30:0]        len_reg;
    logic [30:0]        rem_reg;
    logic [30:0]        num_reg;
    logic [29:0]        quo_reg;
    logic [4:0]         div_cnt_reg;
    logic [1:0]         row_reg;
    logic               m_valid_reg;
    lav_out_t           m_data_reg;

    logic [63:0]        m_or;
    logic [1:0]         ui;
    logic [1:0]         vi;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [63:0] mul_p;
    logic               is_cross;
    logic               acc_first;
    logic               acc_sub;
    logic               mac_last;
    logic signed [63:0] acc_base;
    logic signed [63:0] acc_sum;
    logic [63:0]        sq_bit;
    logic [63:0]        sq_trial;
    logic               sq_ge;
    logic [63:0]        sq_n_next;
    logic [63:0]        sq_res_next;
    logic [63:0]        m_sel;
    logic [61:0]        div_num;
    logic [31:0]        div_r2;
    logic               div_ge;
    logic [30:0]        div_rem_next;
    logic [30:0]        div_q;
    logic signed [31:0] div_val;
    lav_out_t           row_data;

    function automatic logic signed [31:0] round_sat(input logic signed [63:0] p,
                                                     input logic negate);
        logic [63:0] mag;
        logic [63:0] r;
        logic        neg;
        mag = p[63] ? 64'(-p) : 64'(p);
        r   = (mag + RND_HALF) >> FRAC_BITS;
        neg = p[63] ^ negate;
        if (neg) begin
            if (r > 64'h8000_0000) begin
                round_sat = 32'sh8000_0000;
            end else begin
                round_sat = -$signed(r[31:0]);
            end
        end else begin
            if (r > 64'h7fff_ffff) begin
                round_sat = 32'sh7fff_ffff;
            end else begin
                round_sat = $signed(r[31:0]);
            end
        end
    endfunction

    always_comb begin
        m_or = m_reg[0] | m_reg[1] | m_reg[2];

        case (k_reg)
            3'd0: begin ui = 2'd1; vi = 2'd2; end
            3'd1: begin ui = 2'd2; vi = 2'd1; end
            3'd2: begin ui = 2'd2; vi = 2'd0; end
            3'd3: begin ui = 2'd0; vi = 2'd2; end
            3'd4: begin ui = 2'd0; vi = 2'd1; end
            default: begin ui = 2'd1; vi = 2'd0; end
        endcase

        case (op_reg)
            OP_SQ: begin
                op_a = $signed(m_reg[k_reg[1:0]][31:0]);
                op_b = $signed(m_reg[k_reg[1:0]][31:0]);
            end
            OP_CROSS_C: begin
                op_a = up_reg[ui];
                op_b = z_reg[vi];
            end
            OP_CROSS_Y: begin
                op_a = z_reg[ui];
                op_b = x_reg[vi];
            end
            OP_DOT_X: begin
                op_a = x_reg[k_reg[1:0]];
                op_b = eye_reg[k_reg[1:0]];
            end
            OP_DOT_Y: begin
                op_a = y_reg[k_reg[1:0]];
                op_b = eye_reg[k_reg[1:0]];
            end
            default: begin
                op_a = z_reg[k_reg[1:0]];
                op_b = eye_reg[k_reg[1:0]];
            end
        endcase
        mul_p = 64'(op_a) * 64'(op_b);

        is_cross  = (op_reg == OP_CROSS_C) || (op_reg == OP_CROSS_Y);
        acc_first = is_cross ? !k_reg[0] : (k_reg == 3'd0);
        acc_sub   = is_cross && k_reg[0];
        mac_last  = is_cross ? (k_reg == 3'd5) : (k_reg == 3'd2);
        acc_base  = acc_first ? 64'sd0 : acc_reg;
        acc_sum   = acc_sub ? acc_base - prod_reg : acc_base + prod_reg;

        sq_bit      = 64'(1) << {sq_cnt_reg, 1'b0};
        sq_trial    = sq_res_reg + sq_bit;
        sq_ge       = sq_n_reg >= sq_trial;
        sq_n_next   = sq_ge ? sq_n_reg - sq_trial : sq_n_reg;
        sq_res_next = sq_ge ? (sq_res_reg >> 1) + sq_bit : sq_res_reg >> 1;

        m_sel        = m_reg[k_reg[1:0]];
        div_num      = (62'(m_sel[29:0]) << FRAC_BITS) + 62'(len_reg[30:1]);
        div_r2       = {rem_reg, num_reg[30]};
        div_ge       = div_r2 >= {1'b0, len_reg};
        div_rem_next = div_ge ? 31'(div_r2 - {1'b0, len_reg}) : div_r2[30:0];
        div_q        = {quo_reg, div_ge};
        div_val      = neg_reg[k_reg[1:0]] ? -$signed({1'b0, div_q})
                                           : $signed({1'b0, div_q});

        row_data.row_index  = row_reg;
        row_data.degenerate = degen_reg;
        row_data.last_row   = (row_reg == 2'd3);
        if (row_reg == 2'd3) begin
            row_data.col0 = t_reg[0];
            row_data.col1 = t_reg[1];
            row_data.col2 = t_reg[2];
            row_data.col3 = ONE_Q;
        end else begin
            row_data.col0 = x_reg[row_reg];
            row_data.col1 = y_reg[row_reg];
            row_data.col2 = z_reg[row_reg];
            row_data.col3 = 32'sd0;
        end
    end

    assign job_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        eye_reg[0] <= job.eye_x;
                        eye_reg[1] <= job.eye_y;
                        eye_reg[2] <= job.eye_z;
                        up_reg[0]  <= job.up_x;
                        up_reg[1]  <= job.up_y;
                        up_reg[2]  <= job.up_z;
                        vec_reg[0] <= 64'($signed(job.d_x));
                        vec_reg[1] <= 64'($signed(job.d_y));
                        vec_reg[2] <= 64'($signed(job.d_z));
                        pass_reg   <= 1'b0;
                        k_reg      <= 3'd0;
                        if (job.d_zero) begin
                            z_reg[0]  <= 32'sd0;
                            z_reg[1]  <= 32'sd0;
                            z_reg[2]  <= 32'sd0;
                            degen_reg <= 1'b1;
                            op_reg    <= OP_CROSS_C;
                            state_reg <= ST_MUL;
                        end else begin
                            degen_reg <= 1'b0;
                            state_reg <= ST_NRM_INIT;
                        end
                    end
                end
                ST_NRM_INIT: begin
                    for (int i = 0; i < 3; i++) begin
                        m_reg[i]   <= vec_reg[i][63] ? 64'(-vec_reg[i]) : 64'(vec_reg[i]);
                        neg_reg[i] <= vec_reg[i][63];
                    end
                    state_reg <= ST_NRM_SHIFT;
                end
                ST_NRM_SHIFT: begin
                    if (m_or == '0) begin
                        degen_reg <= 1'b1;
                        k_reg     <= 3'd0;
                        for (int i = 0; i < 3; i++) begin
                            if (pass_reg) begin
                                x_reg[i] <= 32'sd0;
                            end else begin
                                z_reg[i] <= 32'sd0;
                            end
                        end
                        op_reg    <= pass_reg ? OP_CROSS_Y : OP_CROSS_C;
                        state_reg <= ST_MUL;
                    end else if (m_or[63:30] != '0) begin
                        for (int i = 0; i < 3; i++) begin
                            m_reg[i] <= m_reg[i] >> 1;
                        end
                    end else if (m_or[63:29] == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            m_reg[i] <= m_reg[i] << 1;
                        end
                    end else begin
                        op_reg    <= OP_SQ;
                        k_reg     <= 3'd0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg <= acc_sum;
                    if (op_reg == OP_CROSS_C && k_reg[0]) begin
                        vec_reg[k_reg[2:1]] <= acc_sum;
                    end
                    if (op_reg == OP_CROSS_Y && k_reg[0]) begin
                        y_reg[k_reg[2:1]] <= round_sat(acc_sum, 1'b0);
                    end
                    if (!mac_last) begin
                        k_reg     <= k_reg + 3'd1;
                        state_reg <= ST_MUL;
                    end else begin
                        k_reg <= 3'd0;
                        case (op_reg)
                            OP_SQ: begin
                                sq_n_reg   <= 64'(acc_sum);
                                sq_res_reg <= '0;
                                sq_cnt_reg <= 5'd31;
                                state_reg  <= ST_SQRT;
                            end
                            OP_CROSS_C: begin
                                pass_reg  <= 1'b1;
                                state_reg <= ST_NRM_INIT;
                            end
                            OP_CROSS_Y: begin
                                op_reg    <= OP_DOT_X;
                                state_reg <= ST_MUL;
                            end
                            OP_DOT_X: begin
                                t_reg[0]  <= round_sat(acc_sum, 1'b1);
                                op_reg    <= OP_DOT_Y;
                                state_reg <= ST_MUL;
                            end
                            OP_DOT_Y: begin
                                t_reg[1]  <= round_sat(acc_sum, 1'b1);
                                op_reg    <= OP_DOT_Z;
                                state_reg <= ST_MUL;
                            end
                            default: begin
                                t_reg[2]  <= round_sat(acc_sum, 1'b1);
                                row_reg   <= 2'd0;
                                state_reg <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_SQRT: begin
                    sq_n_reg   <= sq_n_next;
                    sq_res_reg <= sq_res_next;
                    sq_cnt_reg <= sq_cnt_reg - 5'd1;
                    if (sq_cnt_reg == 5'd0) begin
                        len_reg   <= sq_res_next[30:0];
                        k_reg     <= 3'd0;
                        state_reg <= ST_DIV_INIT;
                    end
                end
                ST_DIV_INIT: begin
                    rem_reg     <= div_num[61:31];
                    num_reg     <= div_num[30:0];
                    quo_reg     <= '0;
                    div_cnt_reg <= 5'd30;
                    state_reg   <= ST_DIV_STEP;
                end
                ST_DIV_STEP: begin
                    rem_reg     <= div_rem_next;
                    num_reg     <= num_reg << 1;
                    quo_reg     <= div_q[29:0];
                    div_cnt_reg <= div_cnt_reg - 5'd1;
                    if (div_cnt_reg == 5'd0) begin
                        if (pass_reg) begin
                            x_reg[k_reg[1:0]] <= div_val;
                        end else begin
                            z_reg[k_reg[1:0]] <= div_val;
                        end
                        if (k_reg == 3'd2) begin
                            k_reg     <= 3'd0;
                            op_reg    <= pass_reg ? OP_CROSS_Y : OP_CROSS_C;
                            state_reg <= ST_MUL;
                        end else begin
                            k_reg     <= k_reg + 3'd1;
                            state_reg <= ST_DIV_INIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= row_data;
                        row_reg     <= row_reg + 2'd1;
                        if (row_reg == 2'd3) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.last_row == (m_data_reg.row_index == 2'd3)))
        else $error("last_row does not match row_index");

    a_col3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.col3 == (m_data_reg.last_row ? ONE_Q : 32'sd0)))
        else $error("col3 wrong for row");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_STEP) |-> (rem_reg < len_reg))
        else $error("divider remainder not below divisor");

    a_scaled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL && op_reg == OP_SQ) |-> (m_or[63:30] == '0 && m_or[29]))
        else $error("vector not scaled into range before squaring");

    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && m_valid_reg && !m_ready) |=> $stable(row_reg))
        else $error("row advanced while result stalled");
`endif

endmodule
`default_nettype wire

### src/look_at_view_matrix.sv
// Look-at view matrix top level: front end, job queue and back end.
// Depends on lav_pkg, lav_front, lav_fifo and lav_back.
//
// Each camera item (eye, target, up; signed fixed point with FRAC_BITS fraction
// bits) produces four result transfers, rows 0 to 3 of the view matrix, in order.
// With both vectors of nonzero length the back end takes the job, then for each
// normalization scales the vector, runs a bit-serial square root and a bit-serial
// division of each component; it forms each cross or dot product on the shared
// multiplier and ends with the four row transfers. A zero view direction or a zero
// cross product of up and view skips the square root and division for that vector,
// and a stalled result holds the back end until the row is taken.
// The front end and a two-entry queue take further items while one is computed,
// and a result register lets a finished row wait while the next is formed.
`default_nettype none
module look_at_view_matrix #(
    parameter int FRAC_BITS = lav_pkg::LAV_FRAC_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire lav_pkg::lav_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lav_pkg::lav_out_t      m_data
);
    import lav_pkg::*;

    logic     push_valid;
    logic     push_ready;
    lav_job_t push_job;
    logic     job_valid;
    logic     job_ready;
    lav_job_t job;

    lav_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    lav_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_job   (push_job),
        .rd_valid (job_valid),
        .rd_ready (job_ready),
        .rd_job   (job)
    );

    lav_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

### tb/sv/look_at_view_matrix_test.sv
// Testbench for look_at_view_matrix: a queue-fed driver, a randomly stalling
// receiver and a bit-exact predictor of the four view matrix rows.
// Depends on lav_pkg and the look_at_view_matrix RTL.
`timescale 1ns / 1ps
module look_at_view_matrix_test;
    import lav_pkg::*;

    localparam int FB = LAV_FRAC_BITS;
    localparam int ITEM_CNT = 400;

    typedef longint vec3_t [3];

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    lav_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    lav_out_t m_data;

    lav_in_t  pending_cams[$];
    lav_out_t expected_rows[$];
    int       error_cnt = 0;
    int       cams_sent = 0;
    int       rows_seen = 0;
    int       degen_cnt = 0;
    int       send_gap = 0;
    int       recv_wait = 0;
    int       hold_off = 0;
    bit       no_idle = 1'b0;

    look_at_view_matrix u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint round_q(longint p);
        longint unsigned m;
        m = (mag(p) + (64'd1 << (FB - 1))) >> FB;
        return (p < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Return 1 on a zero vector.
    function automatic bit unit_vec(input vec3_t v, output vec3_t u);
        longint unsigned m [3];
        longint unsigned mx, sum, len, q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            u = '{0, 0, 0};
            return 1'b1;
        end
        while (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            mx <<= 1;
        end
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FB) + (len >> 1)) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b0;
    endfunction

    task automatic predict_rows(lav_in_t cam);
        vec3_t eye, upv, d, c, x, y, z, t;
        bit degen;
        lav_out_t row;
        eye = '{cam.eye_x, cam.eye_y, cam.eye_z};
        upv = '{cam.upward_x, cam.upward_y, cam.upward_z};
        d = '{eye[0] - cam.target_x, eye[1] - cam.target_y, eye[2] - cam.target_z};
        degen = unit_vec(d, z);
        c[0] = upv[1] * z[2] - upv[2] * z[1];
        c[1] = upv[2] * z[0] - upv[0] * z[2];
        c[2] = upv[0] * z[1] - upv[1] * z[0];
        if (unit_vec(c, x)) degen = 1'b1;
        y[0] = clamp32(round_q(z[1] * x[2] - z[2] * x[1]));
        y[1] = clamp32(round_q(z[2] * x[0] - z[0] * x[2]));
        y[2] = clamp32(round_q(z[0] * x[1] - z[1] * x[0]));
        t[0] = clamp32(-round_q(x[0] * eye[0] + x[1] * eye[1] + x[2] * eye[2]));
        t[1] = clamp32(-round_q(y[0] * eye[0] + y[1] * eye[1] + y[2] * eye[2]));
        t[2] = clamp32(-round_q(z[0] * eye[0] + z[1] * eye[1] + z[2] * eye[2]));
        if (degen) degen_cnt++;
        for (int r = 0; r < 4; r++) begin
            row.row_index  = 2'(r);
            row.col0       = 32'((r < 3) ? x[r] : t[0]);
            row.col1       = 32'((r < 3) ? y[r] : t[1]);
            row.col2       = 32'((r < 3) ? z[r] : t[2]);
            row.col3       = (r < 3) ? 32'sd0 : (32'sd1 <<< FB);
            row.degenerate = degen;
            row.last_row   = (r == 3);
            expected_rows.push_back(row);
        end
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_cnt++;
        end
    endtask

    function automatic logic signed [31:0] near_val();
        return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    function automatic lav_in_t random_cam();
        lav_in_t cam;
        int sel;
        int k;
        sel = $urandom_range(0, 19);
        cam = {$urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        if (sel >= 6 && sel < 13) begin
            cam = {near_val(), near_val(), near_val(), near_val(), near_val(),
                   near_val(), near_val(), near_val(), near_val()};
        end else if (sel >= 13 && sel < 16) begin
            cam.target_x = cam.eye_x + near_val();
            cam.target_y = cam.eye_y + near_val();
            cam.target_z = cam.eye_z + near_val();
            cam.upward_x = near_val();
            cam.upward_y = near_val();
            cam.upward_z = near_val();
        end else if (sel == 16) begin
            cam.target_x = cam.eye_x;
            cam.target_y = cam.eye_y;
            cam.target_z = cam.eye_z;
        end else if (sel == 17) begin
            cam.eye_x = near_val();
            cam.eye_y = near_val();
            cam.eye_z = near_val();
            k = $urandom_range(1, 64);
            cam.upward_x = (cam.eye_x - cam.target_x[19:0]) * k;
            cam.upward_y = (cam.eye_y - cam.target_y[19:0]) * k;
            cam.upward_z = (cam.eye_z - cam.target_z[19:0]) * k;
            cam.target_x = cam.target_x[19:0];
            cam.target_y = cam.target_y[19:0];
            cam.target_z = cam.target_z[19:0];
        end else if (sel == 18) begin
            cam.upward_x = 0;
            cam.upward_y = 0;
            cam.upward_z = 0;
        end
        return cam;
    endfunction

    initial begin
        localparam logic signed [31:0] ONE = 32'sd1 <<< FB;
        localparam logic signed [31:0] MX = 32'sh7fff_ffff;
        localparam logic signed [31:0] MN = 32'sh8000_0000;
        pending_cams.push_back('{0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0});
        pending_cams.push_back('{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0});
        pending_cams.push_back('{0, 0, ONE, 0, 0, 0, 0, 0, 3 * ONE});
        pending_cams.push_back('{0, 0, ONE, 0, 0, 0, 0, 0, 0});
        pending_cams.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        pending_cams.push_back('{MX, MX, MX, 0, 0, 0, 0, ONE, 0});
        pending_cams.push_back('{MN, MN, MN, 0, 0, 0, 0, ONE, 0});
        pending_cams.push_back('{MX, MX, MX, MN, MN, MN, MN, MX, MN});
        pending_cams.push_back('{MN, MX, MN, MX, MN, MX, MX, MN, MX});
        pending_cams.push_back('{MX, 0, MN, MN, 0, MX, 0, MX, 0});
        pending_cams.push_back('{1, 0, 0, 0, 0, 0, 0, 1, 0});
        pending_cams.push_back('{-1, -1, -1, 0, 0, 0, 1, 0, 0});
        pending_cams.push_back('{MX, MN, 0, MN, MX, 0, 0, 0, MX});
        pending_cams.push_back('{3 * ONE, -ONE, 7, -2 * ONE, 5, ONE, -1, -1, -1});
        pending_cams.push_back('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
        pending_cams.push_back('{0, 10 * ONE, 0, 0, 0, 0, 0, ONE, 0});
        while (pending_cams.size() < ITEM_CNT) pending_cams.push_back(random_cam());
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Sender: hold the offered camera until its transfer, then idle a drawn gap.
    always @(posedge aclk) begin
        bit offer;
        if (aresetn) begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                predict_rows(s_data);
                cams_sent++;
                offer = 1'b0;
                if (cams_sent % 50 == 0) no_idle = ~no_idle;
                send_gap = no_idle ? 0 : $urandom_range(0, 15);
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_cams.size() > 0) begin
                    s_data <= pending_cams.pop_front();
                    offer = 1'b1;
                end
            end
            s_valid <= offer;
        end
    end

    // Receiver: check each row, stall a drawn number of cycles, once hold off long.
    always @(posedge aclk) begin
        lav_out_t exp_row;
        bit rdy;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                rows_seen++;
                if (expected_rows.size() == 0) begin
                    $error("unexpected row transfer: row_index %0d", m_data.row_index);
                    error_cnt++;
                end else begin
                    exp_row = expected_rows.pop_front();
                    check_field("row_index", exp_row.row_index, m_data.row_index);
                    check_field("col0", exp_row.col0, m_data.col0);
                    check_field("col1", exp_row.col1, m_data.col1);
                    check_field("col2", exp_row.col2, m_data.col2);
                    check_field("col3", exp_row.col3, m_data.col3);
                    check_field("degenerate", exp_row.degenerate, m_data.degenerate);
                    check_field("last_row", exp_row.last_row, m_data.last_row);
                end
                recv_wait = no_idle ? 0 : $urandom_range(0, 15);
                if (rows_seen == 120) hold_off = 3000;
            end
            if (hold_off > 0) begin
                hold_off--;
                rdy = 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_ready <= rdy;
        end
    end

    initial begin
        @(posedge aresetn);
        while (pending_cams.size() > 0 || s_valid) @(posedge aclk);
        while (expected_rows.size() > 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
        $display("Sent %0d camera items, checked %0d matrix rows, %0d degenerate items.",
                 cams_sent, rows_seen, degen_cnt);
        if (error_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Timeout with %0d rows outstanding", expected_rows.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
